>>> rtl/core/trbeg_pkg.sv
// Shared types and codes of the tape block edge generator.
`timescale 1ns / 1ps

package trbeg_pkg;

   // Request function codes.
   localparam logic [1:0] FUNC_WRITE = 2'd0;
   localparam logic [1:0] FUNC_START = 2'd1;
   localparam logic [1:0] FUNC_EDGE  = 2'd2;

   // Response status codes.
   localparam logic [1:0] STATUS_EDGE     = 2'd0;
   localparam logic [1:0] STATUS_ACCEPT   = 2'd1;
   localparam logic [1:0] STATUS_IDLE_ERR = 2'd2;

   // Configuration register indexes.
   localparam logic [2:0] CSR_PILOT       = 3'd0;
   localparam logic [2:0] CSR_SYNC_FIRST  = 3'd1;
   localparam logic [2:0] CSR_SYNC_SECOND = 3'd2;
   localparam logic [2:0] CSR_ZERO_BIT    = 3'd3;
   localparam logic [2:0] CSR_ONE_BIT     = 3'd4;
   localparam logic [2:0] CSR_FRAME       = 3'd5;

   localparam logic [3:0] BITS_PER_BYTE = 4'd8;

   typedef struct packed {
      logic [1:0]  func;
      logic [15:0] byte_address;
      logic [7:0]  byte_value;
      logic [15:0] block_length;
      logic [15:0] pilot_edges;
      logic [15:0] pause_units;
   } req_type;

   typedef struct packed {
      logic [32:0] edge_tstates;
      logic        block_done;
      logic [1:0]  status;
   } rsp_type;

   typedef struct packed {
      logic [15:0] pilot_duration;
      logic [15:0] sync_first_duration;
      logic [15:0] sync_second_duration;
      logic [15:0] zero_bit_duration;
      logic [15:0] one_bit_duration;
      logic [16:0] frame_duration;
   } cfg_type;

endpackage

>>> rtl/core/trbeg_csr.sv
// Configuration register file of the tape block edge generator.
`timescale 1ns / 1ps

module trbeg_csr
   import trbeg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [16:0] csr_data,
   output cfg_type     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_PILOT:       cfg_in.pilot_duration       = csr_data[15:0];
            CSR_SYNC_FIRST:  cfg_in.sync_first_duration  = csr_data[15:0];
            CSR_SYNC_SECOND: cfg_in.sync_second_duration = csr_data[15:0];
            CSR_ZERO_BIT:    cfg_in.zero_bit_duration    = csr_data[15:0];
            CSR_ONE_BIT:     cfg_in.one_bit_duration     = csr_data[15:0];
            CSR_FRAME:       cfg_in.frame_duration       = csr_data;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pilot_duration       <= 16'd2168;
         cfg_ff.sync_first_duration  <= 16'd667;
         cfg_ff.sync_second_duration <= 16'd735;
         cfg_ff.zero_bit_duration    <= 16'd855;
         cfg_ff.one_bit_duration     <= 16'd1710;
         cfg_ff.frame_duration       <= 17'd69888;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> rtl/core/tape_rom_block_edge_generator_unit.sv
// Top level of the tape block edge generator: sequencer, byte store and response register.
// The result strobe is registered from the execute state that follows acceptance. Busy is high
// during the execute state, and also during a fetch state when an edge request moves on to a
// new data byte and reads the synchronous byte store; a new transaction is taken only when not
// busy. The result strobe cannot be stalled.
// Synchronous active-high reset clears the sequencer and response; request, read data and store are not cleared.
`timescale 1ns / 1ps

module tape_rom_block_edge_generator_unit
   import trbeg_pkg::*;
#(
   parameter int STORE_DEPTH = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [16:0] csr_data
);

   localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

   typedef enum logic [1:0] {
      CTRL_IDLE,
      CTRL_EXEC,
      CTRL_FETCH
   } ctrl_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_PILOT,
      PH_SYNC1,
      PH_SYNC2,
      PH_DATA1,
      PH_DATA2,
      PH_PAUSE
   } phase_type;

   cfg_type cfg;

   ctrl_type    ctrl_ff, ctrl_in;
   phase_type   phase_ff, phase_in;
   logic [15:0] pilot_left_ff, pilot_left_in;
   logic [3:0]  bits_done_ff, bits_done_in;
   logic [16:0] byte_position_ff, byte_position_in;
   logic [7:0]  shift_byte_ff, shift_byte_in;
   logic [15:0] bit_duration_ff, bit_duration_in;
   logic [15:0] stored_length_ff, stored_length_in;
   logic [15:0] stored_pause_ff, stored_pause_in;
   logic        fetch_oob_ff, fetch_oob_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   req_type     req_ff;
   logic [7:0]  store_mem [STORE_DEPTH];
   logic [7:0]  rd_data_ff;
   logic        mem_wr_en;
   logic        mem_rd_en;

   logic [7:0]  step_byte;
   logic [15:0] pilot_dec;

   trbeg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   assign busy      = (ctrl_ff != CTRL_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign pilot_dec = pilot_left_ff - 16'd1;

   // The bit step works on the held byte, or on the byte just read from the store (zero if out of range).
   always_comb begin
      if (ctrl_ff == CTRL_FETCH) begin
         step_byte = fetch_oob_ff ? 8'd0 : rd_data_ff;
      end else begin
         step_byte = shift_byte_ff;
      end
   end

   always_comb begin
      ctrl_in          = ctrl_ff;
      phase_in         = phase_ff;
      pilot_left_in    = pilot_left_ff;
      bits_done_in     = bits_done_ff;
      byte_position_in = byte_position_ff;
      shift_byte_in    = shift_byte_ff;
      bit_duration_in  = bit_duration_ff;
      stored_length_in = stored_length_ff;
      stored_pause_in  = stored_pause_ff;
      fetch_oob_in     = fetch_oob_ff;
      rsp_valid_in     = 1'b0;
      rsp_data_in      = rsp_data_ff;
      mem_wr_en        = 1'b0;
      mem_rd_en        = 1'b0;

      unique case (ctrl_ff)
         CTRL_IDLE: begin
            if (start) begin
               ctrl_in = CTRL_EXEC;
            end
         end
         CTRL_EXEC: begin
            ctrl_in                  = CTRL_IDLE;
            rsp_valid_in             = 1'b1;
            rsp_data_in.edge_tstates = 33'd0;
            rsp_data_in.block_done   = 1'b0;
            rsp_data_in.status       = STATUS_ACCEPT;
            case (req_ff.func)
               FUNC_WRITE: begin
                  mem_wr_en = (17'(req_ff.byte_address) < 17'(STORE_DEPTH));
               end
               FUNC_START: begin
                  stored_length_in = req_ff.block_length;
                  stored_pause_in  = req_ff.pause_units;
                  pilot_left_in    = (req_ff.pilot_edges == 16'd0) ? 16'd1
                                                                   : req_ff.pilot_edges;
                  bits_done_in     = BITS_PER_BYTE;
                  byte_position_in = 17'd0;
                  shift_byte_in    = 8'd0;
                  bit_duration_in  = 16'd0;
                  phase_in         = PH_PILOT;
               end
               FUNC_EDGE: begin
                  rsp_data_in.status = STATUS_EDGE;
                  unique case (phase_ff) inside
                     PH_PILOT: begin
                        rsp_data_in.edge_tstates = 33'(cfg.pilot_duration);
                        pilot_left_in            = pilot_dec;
                        if (pilot_dec == 16'd0) begin
                           phase_in = PH_SYNC1;
                        end
                     end
                     PH_SYNC1: begin
                        rsp_data_in.edge_tstates = 33'(cfg.sync_first_duration);
                        phase_in                 = PH_SYNC2;
                     end
                     PH_DATA1: begin
                        rsp_data_in.edge_tstates = 33'(bit_duration_ff);
                        phase_in                 = PH_DATA2;
                     end
                     PH_SYNC2, PH_DATA2: begin
                        rsp_data_in.edge_tstates = (phase_ff == PH_SYNC2)
                                                   ? 33'(cfg.sync_second_duration)
                                                   : 33'(bit_duration_ff);
                        if (bits_done_ff >= BITS_PER_BYTE) begin
                           if (byte_position_ff == 17'(stored_length_ff)) begin
                              phase_in = PH_PAUSE;
                           end else begin
                              // Next data byte comes from the store in the fetch cycle.
                              mem_rd_en    = 1'b1;
                              fetch_oob_in = !(18'(byte_position_ff) < 18'(STORE_DEPTH));
                              ctrl_in      = CTRL_FETCH;
                           end
                        end else begin
                           shift_byte_in   = {step_byte[6:0], 1'b0};
                           bits_done_in    = bits_done_ff + 4'd1;
                           bit_duration_in = step_byte[7] ? cfg.one_bit_duration
                                                          : cfg.zero_bit_duration;
                           phase_in        = PH_DATA1;
                        end
                     end
                     PH_PAUSE: begin
                        rsp_data_in.edge_tstates = 33'(stored_pause_ff) *
                                                   33'(cfg.frame_duration);
                        rsp_data_in.block_done   = 1'b1;
                        phase_in                 = PH_IDLE;
                     end
                     default: begin
                        rsp_data_in.status = STATUS_IDLE_ERR;
                        phase_in           = PH_IDLE;
                     end
                  endcase
               end
               default: begin
                  rsp_data_in.status = STATUS_ACCEPT;
               end
            endcase
         end
         CTRL_FETCH: begin
            ctrl_in          = CTRL_IDLE;
            byte_position_in = byte_position_ff + 17'd1;
            shift_byte_in    = {step_byte[6:0], 1'b0};
            bits_done_in     = 4'd1;
            bit_duration_in  = step_byte[7] ? cfg.one_bit_duration : cfg.zero_bit_duration;
            phase_in         = PH_DATA1;
         end
         default: begin
            ctrl_in = CTRL_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff          <= CTRL_IDLE;
         phase_ff         <= PH_IDLE;
         pilot_left_ff    <= 16'd0;
         bits_done_ff     <= 4'd0;
         byte_position_ff <= 17'd0;
         shift_byte_ff    <= 8'd0;
         bit_duration_ff  <= 16'd0;
         stored_length_ff <= 16'd0;
         stored_pause_ff  <= 16'd0;
         fetch_oob_ff     <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         rsp_data_ff      <= '0;
      end else begin
         ctrl_ff          <= ctrl_in;
         phase_ff         <= phase_in;
         pilot_left_ff    <= pilot_left_in;
         bits_done_ff     <= bits_done_in;
         byte_position_ff <= byte_position_in;
         shift_byte_ff    <= shift_byte_in;
         bit_duration_ff  <= bit_duration_in;
         stored_length_ff <= stored_length_in;
         stored_pause_ff  <= stored_pause_in;
         fetch_oob_ff     <= fetch_oob_in;
         rsp_valid_ff     <= rsp_valid_in;
         rsp_data_ff      <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_ff <= req_data;
      end
   end

   // Byte store: one write or one read per cycle, read data registered.
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         store_mem[req_ff.byte_address[ADDR_W-1:0]] <= req_ff.byte_value;
      end
      if (mem_rd_en) begin
         rd_data_ff <= store_mem[byte_position_ff[ADDR_W-1:0]];
      end
   end

endmodule

>>> rtl/core/trbeg_checker.sv
// Port-level checker of the tape block edge generator and its bind to the top level.
`timescale 1ns / 1ps

module trbeg_checker
   import trbeg_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   // Every accepted transaction is answered by a response strobe.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_valid)
      else $error("response missing two cycles after accepted transaction");

   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accepted transaction");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status != STATUS_EDGE)) |->
         ((rsp_data.edge_tstates == 33'd0) && !rsp_data.block_done))
      else $error("non-edge response carries edge timing");

endmodule

bind tape_rom_block_edge_generator_unit trbeg_checker u_trbeg_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
